// ===== src/hnd_pkg.sv =====
// Shared types, constants and a helper for the Hamming near-duplicate search core.
package hnd_pkg;

  // Table geometry.
  localparam int unsigned DEPTH = 64;
  localparam int unsigned CW    = $clog2(DEPTH + 1);
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned FP_W  = 64;
  localparam int unsigned IDX_W = 32;
  localparam int unsigned DST_W = 7;

  // Largest meaningful distance; larger settings saturate to it.
  localparam logic [DST_W-1:0] MAX_DIST = DST_W'(FP_W);

  // Operation codes of the input transaction.
  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_QUERY  = 2'd1;
  localparam logic [1:0] OP_CLEAR  = 2'd2;

  // Result status codes.
  localparam logic [2:0] ST_MATCH    = 3'd0;
  localparam logic [2:0] ST_INSERTED = 3'd1;
  localparam logic [2:0] ST_FULL     = 3'd2;
  localparam logic [2:0] ST_NOMATCH  = 3'd3;
  localparam logic [2:0] ST_CLEARED  = 3'd4;

  typedef struct packed {
    logic [1:0]       op;
    logic [IDX_W-1:0] media_index;
    logic [FP_W-1:0]  fingerprint;
  } hnd_in_t;

  typedef struct packed {
    logic [2:0]       status;
    logic [IDX_W-1:0] match_index;
    logic [DST_W-1:0] distance;
    logic             last;
  } hnd_out_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN
  } hnd_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       do_insert;
    logic       do_clear;
    logic       q_start;
    logic       scan_en;
    logic       load_out;
    logic       pop_head;
    logic [2:0] out_status;
  } hnd_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic table_full;
    logic scan_busy;
    logic list_empty;
    logic list_last;
    logic out_free;
  } hnd_stat_t;

  // Population count of a 64-bit word as a byte-wise adder tree.
  function automatic logic [DST_W-1:0] popcnt64(input logic [FP_W-1:0] v);
    logic [3:0]       nib [8];
    logic [DST_W-1:0] sum;
    for (int b = 0; b < 8; b++) begin
      nib[b] = '0;
      for (int k = 0; k < 8; k++) begin
        nib[b] = nib[b] + 4'(v[b*8+k]);
      end
    end
    sum = (DST_W'(nib[0]) + DST_W'(nib[1])) + (DST_W'(nib[2]) + DST_W'(nib[3]))
        + (DST_W'(nib[4]) + DST_W'(nib[5])) + (DST_W'(nib[6]) + DST_W'(nib[7]));
    return sum;
  endfunction

endpackage

// ===== src/hamming_near_duplicate_search_core.sv =====
// Top level of the Hamming near-duplicate search core.
//
//  Channel  Ports                              Direction  Transaction
//  in       in_valid, in_stall, in_data        input      one insert, query or clear
//  out      out_valid, out_stall, out_data     output     one result
//  cfg      cfg_wr_en, cfg_wr_data             input      write of max_distance
//
// Insert and clear give one result each from the result register.
// A query scans the N stored entries through the single read port and popcount stage, then
// drains one result per match (at least one) from the sorted match list.
// Synchronous active-low reset empties the table and clears max_distance.
// A stalled result holds; a new transaction is taken only once the result register frees.
module hamming_near_duplicate_search_core import hnd_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  hnd_in_t          in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output hnd_out_t         out_data,
  input  logic             cfg_wr_en,
  input  logic [DST_W-1:0] cfg_wr_data
);

  hnd_cmd_t  cmd;
  hnd_stat_t stat;

  // Sequencing.
  hnd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_op    (in_data.op),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Storage and compare.
  hnd_datapath u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_data     (in_data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .cmd         (cmd),
    .stat        (stat),
    .out_stall   (out_stall),
    .out_valid   (out_valid),
    .out_data    (out_data)
  );

endmodule

// ===== src/hnd_datapath.sv =====
// Datapath: entry store, distance pipeline, sorted match list and result register.
module hnd_datapath import hnd_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  hnd_in_t          in_data,
  input  logic             cfg_wr_en,
  input  logic [DST_W-1:0] cfg_wr_data,
  input  hnd_cmd_t         cmd,
  output hnd_stat_t        stat,
  input  logic             out_stall,
  output logic             out_valid,
  output hnd_out_t         out_data
);

  logic [DST_W-1:0] max_dist_r;
  logic [DST_W-1:0] limit;
  logic [CW-1:0]    entry_cnt_r;
  logic [CW-1:0]    scan_cnt_r;
  logic [FP_W-1:0]  qfp_r;

  logic [FP_W-1:0]  mem_hash [DEPTH];
  logic [IDX_W-1:0] mem_idx  [DEPTH];

  logic             rd_issue;
  logic             v1_r;
  logic [FP_W-1:0]  h1_r;
  logic [IDX_W-1:0] i1_r;
  logic             v2_r;
  logic [DST_W-1:0] d2_r;
  logic [IDX_W-1:0] i2_r;
  logic [DST_W-1:0] dist1;

  logic [DST_W-1:0] lst_d_r [DEPTH];
  logic [IDX_W-1:0] lst_i_r [DEPTH];
  logic [CW-1:0]    lcnt_r;
  logic [DEPTH-1:0] gt;

  logic             out_valid_r;
  hnd_out_t         out_r;
  logic             table_full;

  // Configuration register and saturated match limit.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_dist_r <= '0;
    end else if (cfg_wr_en) begin
      max_dist_r <= cfg_wr_data;
    end
  end

  assign limit      = (max_dist_r > MAX_DIST) ? MAX_DIST : max_dist_r;
  assign table_full = (entry_cnt_r == CW'(DEPTH));

  // Fill count of the entry store.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_cnt_r <= '0;
    end else if (cmd.do_clear) begin
      entry_cnt_r <= '0;
    end else if (cmd.do_insert && !table_full) begin
      entry_cnt_r <= entry_cnt_r + CW'(1);
    end
  end

  // Entry store: one write port at the fill count, one registered read port for the scan.
  assign rd_issue = cmd.scan_en && (scan_cnt_r != entry_cnt_r);

  always_ff @(posedge clk) begin
    if (cmd.do_insert && !table_full) begin
      mem_hash[entry_cnt_r[AW-1:0]] <= in_data.fingerprint;
      mem_idx[entry_cnt_r[AW-1:0]]  <= in_data.media_index;
    end
    h1_r <= mem_hash[scan_cnt_r[AW-1:0]];
    i1_r <= mem_idx[scan_cnt_r[AW-1:0]];
  end

  // Scan address, query fingerprint and pipeline valid bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_cnt_r <= '0;
      v1_r       <= 1'b0;
      v2_r       <= 1'b0;
    end else begin
      if (cmd.q_start) begin
        scan_cnt_r <= '0;
      end else if (rd_issue) begin
        scan_cnt_r <= scan_cnt_r + CW'(1);
      end
      v1_r <= rd_issue;
      v2_r <= v1_r && (dist1 <= limit);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.q_start) begin
      qfp_r <= in_data.fingerprint;
    end
  end

  // Distance stage: popcount of the XOR with the query.
  assign dist1 = popcnt64(h1_r ^ qfp_r);

  always_ff @(posedge clk) begin
    d2_r <= dist1;
    i2_r <= i1_r;
  end

  // Sorted match list: a new match lands after every entry that is not larger.
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      gt[i] = (CW'(i) >= lcnt_r) || ({lst_d_r[i], lst_i_r[i]} > {d2_r, i2_r});
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < DEPTH; i++) begin
      if (v2_r) begin
        if (gt[i]) begin
          if (i > 0 && gt[(i > 0) ? i - 1 : 0]) begin
            lst_d_r[i] <= lst_d_r[(i > 0) ? i - 1 : 0];
            lst_i_r[i] <= lst_i_r[(i > 0) ? i - 1 : 0];
          end else begin
            lst_d_r[i] <= d2_r;
            lst_i_r[i] <= i2_r;
          end
        end
      end else if (cmd.pop_head && i < DEPTH - 1) begin
        lst_d_r[i] <= lst_d_r[(i < DEPTH - 1) ? i + 1 : i];
        lst_i_r[i] <= lst_i_r[(i < DEPTH - 1) ? i + 1 : i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lcnt_r <= '0;
    end else if (cmd.q_start) begin
      lcnt_r <= '0;
    end else if (v2_r) begin
      lcnt_r <= lcnt_r + CW'(1);
    end else if (cmd.pop_head) begin
      lcnt_r <= lcnt_r - CW'(1);
    end
  end

  // Result register; it takes a new result on a load and empties when the held one leaves.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_r.status <= cmd.out_status;
      if (cmd.pop_head) begin
        out_r.match_index <= lst_i_r[0];
        out_r.distance    <= lst_d_r[0];
        out_r.last        <= (lcnt_r == CW'(1));
      end else begin
        out_r.match_index <= '0;
        out_r.distance    <= '0;
        out_r.last        <= 1'b1;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // Status back to the controller.
  assign stat.table_full = table_full;
  assign stat.scan_busy  = (scan_cnt_r != entry_cnt_r) || v1_r || v2_r;
  assign stat.list_empty = (lcnt_r == '0);
  assign stat.list_last  = (lcnt_r == CW'(1));
  assign stat.out_free   = !out_valid_r || !out_stall;

  // A new result is loaded only into a free result register.
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> stat.out_free)
    else $error("result register overwritten while still held");

  // The head of the match list is never larger than its successor.
  a_list_sorted: assert property (@(posedge clk) disable iff (!rst_n)
    (lcnt_r >= CW'(2)) |-> ({lst_d_r[0], lst_i_r[0]} <= {lst_d_r[1], lst_i_r[1]}))
    else $error("match list out of order");

  // An insert into a table with room raises the fill count by one.
  a_insert_count: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.do_insert && !table_full && !cmd.do_clear) |=>
      (entry_cnt_r == $past(entry_cnt_r) + CW'(1)))
    else $error("fill count did not advance on insert");

endmodule

// ===== src/hnd_ctrl.sv =====
// Controller: state machine sequencing insert, clear, query scan and result drain.
module hnd_ctrl import hnd_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic [1:0] in_op,
  output logic      in_stall,
  input  hnd_stat_t stat,
  output hnd_cmd_t  cmd
);

  hnd_state_t state_r;
  hnd_state_t state_nxt;
  logic       accept;

  assign accept = in_valid && !in_stall;

  // Next-state logic.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept && in_op == OP_QUERY) begin
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (!stat.scan_busy) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (stat.out_free && (stat.list_empty || stat.list_last)) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Output logic: handshake and datapath commands.
  always_comb begin
    in_stall = 1'b1;
    cmd      = '0;
    unique case (state_r)
      S_IDLE: begin
        in_stall = !stat.out_free;
        if (accept) begin
          case (in_op)
            OP_INSERT: begin
              cmd.do_insert  = 1'b1;
              cmd.load_out   = 1'b1;
              cmd.out_status = stat.table_full ? ST_FULL : ST_INSERTED;
            end
            OP_CLEAR: begin
              cmd.do_clear   = 1'b1;
              cmd.load_out   = 1'b1;
              cmd.out_status = ST_CLEARED;
            end
            OP_QUERY: begin
              cmd.q_start = 1'b1;
            end
            default: ;
          endcase
        end
      end
      S_SCAN: begin
        cmd.scan_en = 1'b1;
      end
      S_DRAIN: begin
        if (stat.out_free) begin
          cmd.load_out = 1'b1;
          if (stat.list_empty) begin
            cmd.out_status = ST_NOMATCH;
          end else begin
            cmd.out_status = ST_MATCH;
            cmd.pop_head   = 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  // Input is taken only while idle.
  a_accept_idle: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> (state_r == S_IDLE))
    else $error("transaction accepted outside idle");

  // A query always starts a scan on the next cycle.
  a_query_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_op == OP_QUERY) |=> (state_r == S_SCAN))
    else $error("query did not start a scan");

  // The list is never popped while the scan is still filling it.
  a_no_pop_scan: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.pop_head |-> !stat.scan_busy)
    else $error("match list popped during scan");

endmodule
